// ===== src/hft_pkg.sv =====
// ----------------------------------------------------------------------------
// hft_pkg
// Shared widths, request and status codes, and the update control group
// for the handle table with embedded free list.
// ----------------------------------------------------------------------------
package hft_pkg;

  localparam int SLOT_COUNT_DEF = 128;
  localparam int HANDLE_W       = 7;
  localparam int WORD_W         = 64;
  localparam int REQ_W          = 2;
  localparam int STAT_W         = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_LOOKUP  = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_SET     = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } stat_t;

  // table and head updates decided for one item
  typedef struct packed {
    logic wr_en;
    logic wr_in_use;
    logic head_load;
    logic fill_inc;
  } upd_t;

endpackage

// ===== src/hft_slot_mem.sv =====
// ----------------------------------------------------------------------------
// hft_slot_mem
// Slot storage: one write port, one read port with registered read data.
// Each entry holds the in-use bit above the object or link word.
// ----------------------------------------------------------------------------
module hft_slot_mem #(
  parameter int DEPTH = hft_pkg::SLOT_COUNT_DEF,
  parameter int DW    = hft_pkg::WORD_W + 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);
  import hft_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/hft_exec.sv =====
// ----------------------------------------------------------------------------
// hft_exec
// Request decision logic: checks the handle or the free list head against
// the slot read for the item, and picks the result and the table updates.
// ----------------------------------------------------------------------------
module hft_exec #(
  parameter int SLOT_COUNT = hft_pkg::SLOT_COUNT_DEF
) (
  input  hft_pkg::req_t                      req,
  input  logic [hft_pkg::HANDLE_W-1:0]       handle,
  input  logic [hft_pkg::WORD_W-1:0]         obj,
  input  logic [hft_pkg::WORD_W:0]           slot_data,
  input  logic [$clog2(SLOT_COUNT+1)-1:0]    head,
  output hft_pkg::upd_t                      upd,
  output logic [$clog2(SLOT_COUNT+1)-1:0]    head_next,
  output logic [hft_pkg::WORD_W-1:0]         wr_word,
  output logic [hft_pkg::HANDLE_W-1:0]       grant,
  output logic [hft_pkg::WORD_W-1:0]         found,
  output hft_pkg::stat_t                     stat
);
  import hft_pkg::*;

  localparam int HW = $clog2(SLOT_COUNT + 1);
  localparam int CW = (HW > HANDLE_W) ? HW : HANDLE_W;

  logic [CW-1:0]     h_ext;
  logic [CW-1:0]     head_ext;
  logic              in_use;
  logic [WORD_W-1:0] word;
  logic              h_live;
  logic              list_empty;
  logic [HW-1:0]     head_link;

  assign h_ext      = CW'(handle);
  assign head_ext   = CW'(head);
  assign in_use     = slot_data[WORD_W];
  assign word       = slot_data[WORD_W-1:0];
  assign h_live     = (handle != '0) && (h_ext < CW'(SLOT_COUNT)) && in_use;
  assign list_empty = (head == '0) || (head >= HW'(SLOT_COUNT));
  // a stray link past the end means the list is empty
  assign head_link  = (word > WORD_W'(SLOT_COUNT)) ? HW'(SLOT_COUNT) : word[HW-1:0];

  always_comb begin
    upd       = '0;
    head_next = head;
    wr_word   = obj;
    grant     = '0;
    found     = '0;
    stat      = ST_OK;
    unique case (req)
      REQ_ALLOC: begin
        if (list_empty) begin
          stat = ST_FULL;
        end else begin
          upd.wr_en     = 1'b1;
          upd.wr_in_use = 1'b1;
          upd.head_load = 1'b1;
          upd.fill_inc  = 1'b1;
          head_next     = head_link;
          grant         = head_ext[HANDLE_W-1:0];
        end
      end
      REQ_LOOKUP: begin
        if (!h_live) begin
          stat = ST_BAD;
        end else begin
          found = word;
        end
      end
      REQ_RELEASE: begin
        if (!h_live) begin
          stat = ST_BAD;
        end else begin
          upd.wr_en     = 1'b1;
          upd.head_load = 1'b1;
          wr_word       = WORD_W'(head);
          head_next     = h_ext[HW-1:0];
        end
      end
      REQ_SET: begin
        if (!h_live) begin
          stat = ST_BAD;
        end else begin
          upd.wr_en     = 1'b1;
          upd.wr_in_use = 1'b1;
        end
      end
      default: begin
        stat = ST_BAD;
      end
    endcase
  end

endmodule

// ===== src/handle_table_free_list.sv =====
// ----------------------------------------------------------------------------
// handle_table_free_list
// Fixed-size handle table whose free slots are chained through the table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall) carries req_type, slot_handle and
//   object_value; allocate, lookup, release and set each give exactly one
//   result item on the out_valid / out_stall channel with new_handle,
//   object_out and status.
//   An item passes an input register, a slot read (registered memory
//   output), the decision logic and the result register. One item is
//   accepted every cycle while the receiver does not stall; the slot
//   memory port and a one-entry write-to-read bypass keep back-to-back
//   items on the same slot or on the free list head consistent.
//   Handles 1 .. SLOT_COUNT-1 are usable; slot 0 is never granted.
//   Reset empties the pipeline, sets the free list head to slot 1 and
//   marks every usable slot free. No clearing pass runs: a fill mark
//   tracks the slots never written, which read as free with a link to
//   the next slot, so items are taken from the first cycle after reset.
//   When the receiver stalls, the result register holds; the stages behind
//   it keep filling and in_stall rises once they are all occupied.
// ----------------------------------------------------------------------------
module handle_table_free_list #(
  parameter int SLOT_COUNT = hft_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hft_pkg::REQ_W-1:0]    req_type,
  input  logic [hft_pkg::HANDLE_W-1:0] slot_handle,
  input  logic [hft_pkg::WORD_W-1:0]   object_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hft_pkg::HANDLE_W-1:0] new_handle,
  output logic [hft_pkg::WORD_W-1:0]   object_out,
  output logic [hft_pkg::STAT_W-1:0]   status
);
  import hft_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int HW = $clog2(SLOT_COUNT + 1);
  localparam int CW = (HW > HANDLE_W) ? HW : HANDLE_W;
  localparam int DW = WORD_W + 1;

  // input stage
  logic                s1_valid;
  req_t                s1_req;
  logic [HANDLE_W-1:0] s1_handle;
  logic [WORD_W-1:0]   s1_obj;

  // decision stage
  logic                s2_valid;
  req_t                s2_req;
  logic [HANDLE_W-1:0] s2_handle;
  logic [WORD_W-1:0]   s2_obj;
  logic [AW-1:0]       s2_addr;
  logic                s2_unwr;
  logic                s2_fwd;
  logic [DW-1:0]       s2_fwd_data;

  // free list head and fill mark
  logic [HW-1:0] head;
  logic [HW-1:0] fill;

  // result register
  logic [HANDLE_W-1:0] out_handle;
  logic [WORD_W-1:0]   out_obj;
  logic [STAT_W-1:0]   out_stat;

  logic                adv_out;
  logic                commit;
  logic                s2_free;
  logic                s1_move;
  logic                in_take;
  logic [HW-1:0]       head_eff;
  logic [HW-1:0]       fill_eff;
  logic [CW-1:0]       h1_ext;
  logic [AW-1:0]       rd_addr;
  logic                rd_unwr;
  logic [DW-1:0]       rd_data;
  logic [DW-1:0]       slot_data;
  logic                wr_en;
  logic [DW-1:0]       wr_data;
  logic                fwd;

  upd_t                upd;
  logic [HW-1:0]       head_next;
  logic [WORD_W-1:0]   wr_word;
  logic [HANDLE_W-1:0] grant;
  logic [WORD_W-1:0]   found;
  stat_t               stat;

  assign adv_out  = !out_valid || !out_stall;
  assign commit   = s2_valid && adv_out;
  assign s2_free  = !s2_valid || adv_out;
  assign s1_move  = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign in_take  = in_valid && !in_stall;

  // head and fill mark as they stand after the item committing now
  assign head_eff = (commit && upd.head_load) ? head_next : head;
  assign fill_eff = (commit && upd.fill_inc && s2_unwr) ? fill + HW'(1) : fill;

  assign h1_ext  = CW'(s1_handle);
  assign rd_addr = (s1_req == REQ_ALLOC) ? head_eff[AW-1:0] : h1_ext[AW-1:0];
  assign rd_unwr = HW'(rd_addr) >= fill_eff;

  assign wr_en   = commit && upd.wr_en;
  assign wr_data = {upd.wr_in_use, wr_word};
  assign fwd     = wr_en && (s2_addr == rd_addr);

  // never-written slots read as free, linked to the next slot
  assign slot_data = s2_fwd  ? s2_fwd_data :
                     s2_unwr ? {1'b0, WORD_W'(s2_addr) + WORD_W'(1)} :
                     rd_data;

  hft_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s2_addr),
    .wr_data (wr_data),
    .rd_en   (s1_move),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hft_exec #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_exec (
    .req       (s2_req),
    .handle    (s2_handle),
    .obj       (s2_obj),
    .slot_data (slot_data),
    .head      (head),
    .upd       (upd),
    .head_next (head_next),
    .wr_word   (wr_word),
    .grant     (grant),
    .found     (found),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req    <= req_t'(req_type);
      s1_handle <= slot_handle;
      s1_obj    <= object_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (commit) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_req      <= s1_req;
      s2_handle   <= s1_handle;
      s2_obj      <= s1_obj;
      s2_addr     <= rd_addr;
      s2_unwr     <= rd_unwr;
      s2_fwd      <= fwd;
      s2_fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= HW'(1);
      fill <= HW'(1);
    end else begin
      head <= head_eff;
      fill <= fill_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_handle <= grant;
      out_obj    <= found;
      out_stat   <= stat;
    end
  end

  assign new_handle = out_handle;
  assign object_out = out_obj;
  assign status     = out_stat;

endmodule

// ===== src/hft_checker.sv =====
// ----------------------------------------------------------------------------
// hft_checker
// Port-level checks on result items of the handle table, bound to the top.
// ----------------------------------------------------------------------------
module hft_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [hft_pkg::HANDLE_W-1:0] new_handle,
  input logic [hft_pkg::WORD_W-1:0]   object_out,
  input logic [hft_pkg::STAT_W-1:0]   status
);
  import hft_pkg::*;

  // a rejected request carries no handle and no object
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (new_handle == '0) && (object_out == '0))
    else $error("failed request carries a handle or an object");

  // a granted handle and a looked-up object never come together
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (new_handle != '0) |-> (status == ST_OK) && (object_out == '0))
    else $error("granted handle with bad status or object");

  // no result right after reset, and no input pressure left over
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or stall right after reset");

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(new_handle) && $stable(object_out))
    else $error("stalled result changed");

  // input side never stalls without a reason downstream
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is free");

endmodule

bind handle_table_free_list hft_checker u_hft_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .new_handle (new_handle),
  .object_out (object_out),
  .status     (status)
);
